FILE: src/stet_pkg.sv
// Package for the sorted timer expiry table: transfer structs, command and
// event codes, sequencer states and the stored slot layout. No dependencies.
`default_nettype none

package stet_pkg;

    localparam int DEF_TIMER_SLOTS = 16;

    // input commands
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;

    // result kinds
    localparam logic [2:0] EV_ADDED   = 3'd0;
    localparam logic [2:0] EV_FULL    = 3'd1;
    localparam logic [2:0] EV_DELETED = 3'd2;
    localparam logic [2:0] EV_MISSING = 3'd3;
    localparam logic [2:0] EV_EXPIRED = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] timer_id;
        logic [15:0] duration;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] event_id;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] start;
        logic [15:0] duration;
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: src/sorted_timer_expiry_table_top.sv
// Sorted timer expiry table, top level: sequencer, compare unit and slot RAM.
// Depends on stet_pkg and stet_ram.
//
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_data): one command per
//   transfer: tick, add or delete by id. Output channel (o_out_valid /
//   i_out_stall / o_out_data): events, the last one of each command flagged;
//   a tick with no expiries and the unused command code give no event.
//   Timers sit in a RAM sorted by duration ascending, a new timer in front of
//   those of equal duration; each entry is visited as a RAM read (S_RD),
//   then a compare and write back (S_EX), by one shared subtract/compare unit.
//   A tick or a delete walks every live entry; an add walks down from the
//   tail over the entries whose duration is not below the new one, landing
//   at the head when that is all of them; a rejected add does no walk.
//   o_in_stall is high while the sequencer is busy with a command; the next
//   command is taken even while the last event still waits for the receiver.
//   Expiries go out in table order, each held back until the next one is
//   found or the walk ends, so that last can be set on the final one. A
//   stalled receiver holds the output register; the walk waits for it only
//   when a further expiry or the command's final event has to go out.
//   Reset (synchronous, active low) empties the table and clears the tick
//   counter at once; RAM contents are not cleared as only live slots are read.
`default_nettype none

module sorted_timer_expiry_table_top #(
    parameter int TIMER_SLOTS = stet_pkg::DEF_TIMER_SLOTS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire stet_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output stet_pkg::t_out     o_out_data
);

    localparam int AW = $clog2(TIMER_SLOTS);      // slot address bits
    localparam int CW = $clog2(TIMER_SLOTS + 1);  // count bits, holds TIMER_SLOTS
    localparam logic [CW-1:0] FULL_CNT = CW'(TIMER_SLOTS);

    // sequencer and datapath registers
    stet_pkg::t_state r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;
    logic [15:0]      r_id, n_id;
    logic [15:0]      r_dur, n_dur;
    logic             r_full, n_full;
    logic [CW-1:0]    r_idx, n_idx;     // read index (add: one above next read)
    logic [CW-1:0]    r_wr, n_wr;       // compaction write pointer
    logic [CW-1:0]    r_used, n_used;
    logic [31:0]      r_tick, n_tick;
    logic             r_found, n_found;
    logic             r_pend_valid, n_pend_valid;
    logic [15:0]      r_pend_id, n_pend_id;
    logic             r_out_valid;
    stet_pkg::t_out   r_out;

    // RAM interface
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    stet_pkg::t_slot       ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [$bits(stet_pkg::t_slot)-1:0] ram_rdata;
    stet_pkg::t_slot       rd_slot;
    stet_pkg::t_slot       new_slot;

    // emit request into the output register
    logic                  emit;
    stet_pkg::t_out        emit_data;

    // shared decisions
    logic        out_free;
    logic        fwd_scan;     // tick and delete walk forwards
    logic        scan_end;
    logic [31:0] elapsed;
    logic        expired;
    logic        remove;
    logic        ex_hold;
    logic        add_shift;
    logic        fin_done;

    stet_ram #(
        .WIDTH ($bits(stet_pkg::t_slot)),
        .DEPTH (TIMER_SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign rd_slot  = stet_pkg::t_slot'(ram_rdata);
    assign new_slot = '{id: r_id, start: r_tick, duration: r_dur};

    assign out_free = !r_out_valid || !i_out_stall;
    assign fwd_scan = (r_cmd == stet_pkg::CMD_TICK) || (r_cmd == stet_pkg::CMD_DEL);
    assign scan_end = fwd_scan ? (r_idx == r_used) : (r_idx == '0);

    // the shared compare unit: wrap-around elapsed time against duration
    assign elapsed = r_tick - rd_slot.start;
    assign expired = elapsed > {16'd0, rd_slot.duration};
    assign remove  = (r_cmd == stet_pkg::CMD_TICK) ? expired
                                                   : (!r_found && rd_slot.id == r_id);
    // a second expiry cannot go out while the held one is blocked
    assign ex_hold   = (r_cmd == stet_pkg::CMD_TICK) && remove && r_pend_valid && !out_free;
    assign add_shift = rd_slot.duration >= r_dur;
    assign fin_done  = out_free || ((r_cmd == stet_pkg::CMD_TICK) && !r_pend_valid);

    assign o_in_stall  = (r_state != stet_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stet_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.command)
                        stet_pkg::CMD_TICK,
                        stet_pkg::CMD_DEL: n_state = stet_pkg::S_RD;
                        stet_pkg::CMD_ADD: begin
                            n_state = (r_used == FULL_CNT) ? stet_pkg::S_FIN : stet_pkg::S_RD;
                        end
                        default:           n_state = stet_pkg::S_IDLE;
                    endcase
                end
            end
            stet_pkg::S_RD: begin
                n_state = scan_end ? stet_pkg::S_FIN : stet_pkg::S_EX;
            end
            stet_pkg::S_EX: begin
                if (fwd_scan) begin
                    n_state = ex_hold ? stet_pkg::S_EX : stet_pkg::S_RD;
                end else begin
                    n_state = add_shift ? stet_pkg::S_RD : stet_pkg::S_FIN;
                end
            end
            stet_pkg::S_FIN: begin
                if (fin_done) begin
                    n_state = stet_pkg::S_IDLE;
                end
            end
            default: n_state = stet_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM controls and event generation
    always_comb begin
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_dur        = r_dur;
        n_full       = r_full;
        n_idx        = r_idx;
        n_wr         = r_wr;
        n_used       = r_used;
        n_tick       = r_tick;
        n_found      = r_found;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        ram_we       = 1'b0;
        ram_waddr    = r_wr[AW-1:0];
        ram_wdata    = rd_slot;
        ram_re       = 1'b0;
        ram_raddr    = r_idx[AW-1:0];
        emit         = 1'b0;
        emit_data    = '{event_kind: stet_pkg::EV_ADDED, event_id: r_id, last: 1'b1};

        unique case (r_state)
            stet_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_in_data.command;
                    n_id         = i_in_data.timer_id;
                    n_dur        = i_in_data.duration;
                    n_full       = (r_used == FULL_CNT);
                    n_found      = 1'b0;
                    n_pend_valid = 1'b0;
                    n_wr         = '0;
                    n_idx        = (i_in_data.command == stet_pkg::CMD_ADD) ? r_used : '0;
                    if (i_in_data.command == stet_pkg::CMD_TICK) begin
                        n_tick = r_tick + 32'd1;
                    end
                end
            end
            stet_pkg::S_RD: begin
                if (fwd_scan) begin
                    ram_re    = !scan_end;
                    ram_raddr = r_idx[AW-1:0];
                end else if (scan_end) begin
                    // every entry moved up: new timer goes to the head
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = new_slot;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx - 1'b1);
                end
            end
            stet_pkg::S_EX: begin
                if (fwd_scan) begin
                    if (!remove) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wr[AW-1:0];
                        ram_wdata = rd_slot;
                        n_wr      = r_wr + 1'b1;
                        n_idx     = r_idx + 1'b1;
                    end else if (r_cmd == stet_pkg::CMD_DEL) begin
                        n_found = 1'b1;
                        n_idx   = r_idx + 1'b1;
                    end else if (!ex_hold) begin
                        emit         = r_pend_valid;
                        emit_data    = '{event_kind: stet_pkg::EV_EXPIRED,
                                         event_id: r_pend_id, last: 1'b0};
                        n_pend_valid = 1'b1;
                        n_pend_id    = rd_slot.id;
                        n_idx        = r_idx + 1'b1;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    if (add_shift) begin
                        ram_wdata = rd_slot;
                        n_idx     = r_idx - 1'b1;
                    end else begin
                        ram_wdata = new_slot;
                    end
                end
            end
            stet_pkg::S_FIN: begin
                if (fin_done) begin
                    n_pend_valid = 1'b0;
                    case (r_cmd)
                        stet_pkg::CMD_TICK: begin
                            emit      = r_pend_valid;
                            emit_data = '{event_kind: stet_pkg::EV_EXPIRED,
                                          event_id: r_pend_id, last: 1'b1};
                            n_used    = r_wr;
                        end
                        stet_pkg::CMD_ADD: begin
                            emit = 1'b1;
                            if (r_full) begin
                                emit_data.event_kind = stet_pkg::EV_FULL;
                            end else begin
                                emit_data.event_kind = stet_pkg::EV_ADDED;
                                n_used = r_used + 1'b1;
                            end
                        end
                        stet_pkg::CMD_DEL: begin
                            emit = 1'b1;
                            emit_data.event_kind = r_found ? stet_pkg::EV_DELETED
                                                           : stet_pkg::EV_MISSING;
                            n_used = r_wr;
                        end
                        default: emit = 1'b0;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stet_pkg::S_IDLE;
            r_used       <= '0;
            r_tick       <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_tick       <= n_tick;
            r_found      <= n_found;
            r_pend_valid <= n_pend_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_dur     <= n_dur;
        r_full    <= n_full;
        r_idx     <= n_idx;
        r_wr      <= n_wr;
        r_pend_id <= n_pend_id;
        if (emit) begin
            r_out <= emit_data;
        end
    end

    // table never overfills
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_CNT)
        else $error("slot count above table size");

    // compaction write never overtakes the read index
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stet_pkg::S_EX && fwd_scan) |-> (r_wr <= r_idx))
        else $error("write pointer ahead of read index");

    // add walk only examines an entry that exists
    a_add_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stet_pkg::S_EX && r_cmd == stet_pkg::CMD_ADD) |-> (r_idx != '0))
        else $error("add walk below table head");

    // a held expiry only exists during a tick
    a_pend_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_cmd == stet_pkg::CMD_TICK))
        else $error("held expiry outside a tick");

    // an accepted tick advances time by exactly one
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.command == stet_pkg::CMD_TICK)
        |=> (r_tick == $past(r_tick) + 32'd1))
        else $error("tick counter did not advance");

    // the walk never emits into a blocked output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("event written over a waiting transfer");

endmodule

`default_nettype wire

FILE: src/stet_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module stet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
